// File: rtl/vat_pkg.sv
// ----------------------------------------------------------------------------
// vat_pkg: shared types and constants for the vertex affine transform
// Payload structs, register indexes, operation codes and the sine table
// generator used at elaboration.
// ----------------------------------------------------------------------------
package vat_pkg;

  // Register indexes on the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AMOUNT_Z = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd5;

  // Transform modes
  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_SCALE     = 2'd1;
  localparam logic [1:0] MODE_REFLECT   = 2'd2;
  localparam logic [1:0] MODE_ROTATE    = 2'd3;

  // Axis / plane codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam int CFG_DATA_W = 32;
  localparam int ANGLE_W    = 10;
  localparam int COORD_W    = 32;
  localparam int TAG_W      = 16;

  // Width of the exact sum before rounding and saturation
  localparam int SUM_W = 66;

  // pi in Q2.30
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Per-coordinate operation
  typedef enum logic [2:0] {
    OP_PASS,
    OP_ADD,
    OP_NEG,
    OP_SCALE,
    OP_ROT
  } lane_kind_t;

  // Operands of one coordinate lane: result = a*b + v*t (or a, a+b, -a)
  typedef struct packed {
    lane_kind_t                 kind;
    logic signed [COORD_W-1:0] a;
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] v;
    logic signed [COORD_W-1:0] t;
  } lane_op_t;

  // Load enables of the lane pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic signed [COORD_W-1:0] vertex_z;
    logic        [TAG_W-1:0]   vertex_tag;
    logic                      last_in;
  } vertex_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic        [TAG_W-1:0]   out_tag;
    logic                      last_out;
    logic                      overflow;
  } result_t;

  // Sine of k degrees in Q1.tfb, by a Taylor series in Q30 (elaboration only)
  function automatic logic [31:0] trig_entry(input int k, input int tfb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    int          n;
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (n = 1; n <= 12; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if ((n % 2) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    return 32'((sum + (longint'(1) << (29 - tfb))) >>> (30 - tfb));
  endfunction

endpackage

// File: rtl/vat_trig.sv
// ----------------------------------------------------------------------------
// vat_trig: rotation angle latch
// Reduces a written angle to 0..359 degrees, looks up sine and cosine in a
// quarter-wave table and holds them until the next angle write.
// ----------------------------------------------------------------------------
module vat_trig #(
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 angle_write,
  input  logic signed [vat_pkg::ANGLE_W-1:0]   angle,
  output logic signed [TRIG_FRAC_BITS+1:0]     sine,
  output logic signed [TRIG_FRAC_BITS+1:0]     cosine
);

  localparam int TAB_W  = TRIG_FRAC_BITS + 1;
  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int RED_W  = vat_pkg::ANGLE_W + 1;

  // Quarter-wave table, entries 0..90 degrees
  logic [TAB_W-1:0] tab [0:90];

  for (genvar k = 0; k <= 90; k++) begin : g_tab
    assign tab[k] = TAB_W'(vat_pkg::trig_entry(k, TRIG_FRAC_BITS));
  end

  logic signed [RED_W-1:0] a_ext;
  logic signed [RED_W-1:0] a_red;
  logic        [8:0]       a_deg;
  logic        [6:0]       sidx;
  logic        [6:0]       cidx;
  logic                    sneg;
  logic                    cneg;
  logic        [TRIG_W-1:0] s_mag;
  logic        [TRIG_W-1:0] c_mag;
  logic signed [TRIG_W-1:0] sine_next;
  logic signed [TRIG_W-1:0] cosine_next;

  // Angle modulo 360 into 0..359
  always_comb begin
    a_ext = {angle[vat_pkg::ANGLE_W-1], angle};
    priority if (a_ext >= RED_W'(360)) begin
      a_red = a_ext - RED_W'(360);
    end else if (a_ext < -RED_W'(360)) begin
      a_red = a_ext + RED_W'(720);
    end else if (a_ext < 0) begin
      a_red = a_ext + RED_W'(360);
    end else begin
      a_red = a_ext;
    end
    a_deg = a_red[8:0];
  end

  // Quadrant folding
  always_comb begin
    priority if (a_deg < 9'd90) begin
      sidx = a_deg[6:0];
      cidx = 7'(9'd90 - a_deg);
      sneg = 1'b0;
      cneg = 1'b0;
    end else if (a_deg < 9'd180) begin
      sidx = 7'(9'd180 - a_deg);
      cidx = 7'(a_deg - 9'd90);
      sneg = 1'b0;
      cneg = 1'b1;
    end else if (a_deg < 9'd270) begin
      sidx = 7'(a_deg - 9'd180);
      cidx = 7'(9'd270 - a_deg);
      sneg = 1'b1;
      cneg = 1'b1;
    end else begin
      sidx = 7'(9'd360 - a_deg);
      cidx = 7'(a_deg - 9'd270);
      sneg = 1'b1;
      cneg = 1'b0;
    end
  end

  always_comb begin
    s_mag       = {1'b0, tab[sidx]};
    c_mag       = {1'b0, tab[cidx]};
    sine_next   = sneg ? -signed'(s_mag) : signed'(s_mag);
    cosine_next = cneg ? -signed'(c_mag) : signed'(c_mag);
  end

  // Latched sine and cosine, reset to angle zero
  always_ff @(posedge clk) begin
    if (rst) begin
      sine   <= '0;
      cosine <= TRIG_W'(1) << TRIG_FRAC_BITS;
    end else if (angle_write) begin
      sine   <= sine_next;
      cosine <= cosine_next;
    end
  end

endmodule

// File: rtl/vat_opsel.sv
// ----------------------------------------------------------------------------
// vat_opsel: operand select
// Maps mode and axis onto one operation and its operands for each of the
// three coordinate lanes.
// ----------------------------------------------------------------------------
module vat_opsel (
  input  vat_pkg::vertex_t                       vertex,
  input  logic [1:0]                             mode,
  input  logic [1:0]                             axis,
  input  logic signed [vat_pkg::COORD_W-1:0]     amount_x,
  input  logic signed [vat_pkg::COORD_W-1:0]     amount_y,
  input  logic signed [vat_pkg::COORD_W-1:0]     amount_z,
  input  logic signed [vat_pkg::COORD_W-1:0]     sine,
  input  logic signed [vat_pkg::COORD_W-1:0]     cosine,
  output vat_pkg::lane_op_t                      op_x,
  output vat_pkg::lane_op_t                      op_y,
  output vat_pkg::lane_op_t                      op_z
);

  logic [1:0] ax;
  logic signed [vat_pkg::COORD_W-1:0] x;
  logic signed [vat_pkg::COORD_W-1:0] y;
  logic signed [vat_pkg::COORD_W-1:0] z;
  logic signed [vat_pkg::COORD_W-1:0] nsine;

  assign x     = vertex.vertex_x;
  assign y     = vertex.vertex_y;
  assign z     = vertex.vertex_z;
  assign nsine = -sine;
  // Axis code three acts as z
  assign ax    = (axis > vat_pkg::AXIS_Z) ? vat_pkg::AXIS_Z : axis;

  always_comb begin
    // Default: every lane passes its coordinate
    op_x = '{kind: vat_pkg::OP_PASS, a: x, b: '0, v: '0, t: '0};
    op_y = '{kind: vat_pkg::OP_PASS, a: y, b: '0, v: '0, t: '0};
    op_z = '{kind: vat_pkg::OP_PASS, a: z, b: '0, v: '0, t: '0};
    unique case (mode)
      vat_pkg::MODE_TRANSLATE: begin
        op_x = '{kind: vat_pkg::OP_ADD, a: x, b: amount_x, v: '0, t: '0};
        op_y = '{kind: vat_pkg::OP_ADD, a: y, b: amount_y, v: '0, t: '0};
        op_z = '{kind: vat_pkg::OP_ADD, a: z, b: amount_z, v: '0, t: '0};
      end
      vat_pkg::MODE_SCALE: begin
        op_x = '{kind: vat_pkg::OP_SCALE, a: x, b: amount_x, v: '0, t: '0};
        op_y = '{kind: vat_pkg::OP_SCALE, a: y, b: amount_y, v: '0, t: '0};
        op_z = '{kind: vat_pkg::OP_SCALE, a: z, b: amount_z, v: '0, t: '0};
      end
      vat_pkg::MODE_REFLECT: begin
        unique case (ax)
          vat_pkg::AXIS_X: op_x.kind = vat_pkg::OP_NEG;
          vat_pkg::AXIS_Y: op_y.kind = vat_pkg::OP_NEG;
          default:         op_z.kind = vat_pkg::OP_NEG;
        endcase
      end
      vat_pkg::MODE_ROTATE: begin
        unique case (ax)
          vat_pkg::AXIS_X: begin
            op_y = '{kind: vat_pkg::OP_ROT, a: y, b: cosine, v: z, t: nsine};
            op_z = '{kind: vat_pkg::OP_ROT, a: z, b: cosine, v: y, t: sine};
          end
          vat_pkg::AXIS_Y: begin
            op_x = '{kind: vat_pkg::OP_ROT, a: x, b: cosine, v: z, t: sine};
            op_z = '{kind: vat_pkg::OP_ROT, a: z, b: cosine, v: x, t: nsine};
          end
          default: begin
            op_x = '{kind: vat_pkg::OP_ROT, a: x, b: cosine, v: y, t: nsine};
            op_y = '{kind: vat_pkg::OP_ROT, a: y, b: cosine, v: x, t: sine};
          end
        endcase
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/vat_lane.sv
// ----------------------------------------------------------------------------
// vat_lane: one coordinate lane
// Three register stages: multiply, exact sum with rounding shift, and
// saturation to signed 32 bits with an overflow bit.
// ----------------------------------------------------------------------------
module vat_lane #(
  parameter int FRAC_BITS      = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  vat_pkg::stage_en_t                  en,
  input  vat_pkg::lane_op_t                   op,
  output logic signed [vat_pkg::COORD_W-1:0]  value,
  output logic                                ov
);

  localparam int SW = vat_pkg::SUM_W;
  localparam int PW = 2 * vat_pkg::COORD_W;
  localparam logic signed [SW-1:0] RND_SCALE = SW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] RND_ROT   = SW'(1) << (TRIG_FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAX_V     = SW'(32'h7fff_ffff);
  localparam logic signed [SW-1:0] MIN_V     = -MAX_V - SW'(1);

  vat_pkg::lane_kind_t    kind1;
  logic signed [PW-1:0]   p1;
  logic signed [PW-1:0]   p2;
  logic signed [PW-1:0]   p1_next;
  logic signed [PW-1:0]   p2_next;
  logic signed [PW-1:0]   a_ext;
  logic signed [PW-1:0]   b_ext;
  logic signed [PW-1:0]   v_ext;
  logic signed [PW-1:0]   t_ext;
  logic signed [SW-1:0]   sum;
  logic signed [SW-1:0]   r2;
  logic signed [SW-1:0]   r2_next;

  // Stage 1: products, or the plain operands for add / negate / pass
  always_comb begin
    a_ext = PW'(op.a);
    b_ext = PW'(op.b);
    v_ext = PW'(op.v);
    t_ext = PW'(op.t);
    unique case (op.kind)
      vat_pkg::OP_SCALE: begin
        p1_next = a_ext * b_ext;
        p2_next = '0;
      end
      vat_pkg::OP_ROT: begin
        p1_next = a_ext * b_ext;
        p2_next = v_ext * t_ext;
      end
      vat_pkg::OP_ADD: begin
        p1_next = a_ext;
        p2_next = b_ext;
      end
      vat_pkg::OP_NEG: begin
        p1_next = -a_ext;
        p2_next = '0;
      end
      default: begin
        p1_next = a_ext;
        p2_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      kind1 <= op.kind;
      p1    <= p1_next;
      p2    <= p2_next;
    end
  end

  // Stage 2: exact sum, rounded once, half up, for scale and rotate
  always_comb begin
    sum = SW'(p1) + SW'(p2);
    unique case (kind1)
      vat_pkg::OP_SCALE: r2_next = (sum + RND_SCALE) >>> FRAC_BITS;
      vat_pkg::OP_ROT:   r2_next = (sum + RND_ROT) >>> TRIG_FRAC_BITS;
      default:           r2_next = sum;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      r2 <= r2_next;
    end
  end

  // Stage 3: saturate to signed 32 bits
  always_ff @(posedge clk) begin
    if (en.s3) begin
      priority if (r2 > MAX_V) begin
        value <= vat_pkg::COORD_W'(MAX_V);
        ov    <= 1'b1;
      end else if (r2 < MIN_V) begin
        value <= vat_pkg::COORD_W'(MIN_V);
        ov    <= 1'b1;
      end else begin
        value <= vat_pkg::COORD_W'(r2);
        ov    <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/vertex_affine_transform_3d_core.sv
// ----------------------------------------------------------------------------
// vertex_affine_transform_3d_core: streaming 3D vertex transform
// Applies one configured translate, scale, reflect or rotate to a stream of
// Q16.16 vertices, with rounding, saturation and an overflow flag.
//
// Usage:
//  - Input channel vtx (vtx_valid / vtx_stall) carries one vertex per
//    transfer; output channel res (res_valid / res_stall) returns one
//    transformed vertex per input, in order, with tag and last copied.
//  - Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
//    written by the user only while no vertex is in flight; the block does not
//    enforce it. Angle writes latch sine and cosine from a quarter-wave table.
//  - Four pipeline stages: operand select, multiply, sum and round,
//    saturate, each registered. One vertex per clock is sustained while
//    res_stall is low; the multiply stage is a 32x32 multiply.
//  - Stalls: each stage advances when its successor is empty or advancing,
//    so bubbles are squeezed out and vtx_stall rises only when all four
//    stages hold a vertex and res_stall is high. Nothing is lost or repeated.
//  - Reset empties the pipeline, clears the configuration registers and the
//    latched sine, and sets the latched cosine to one.
// ----------------------------------------------------------------------------
module vertex_affine_transform_3d_core #(
  parameter int FRAC_BITS      = 16,
  parameter int TRIG_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                vtx_valid,
  output logic                                vtx_stall,
  input  vat_pkg::vertex_t                    vtx,
  output logic                                res_valid,
  input  logic                                res_stall,
  output vat_pkg::result_t                    res,
  input  logic                                cfg_write,
  input  logic [vat_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vat_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int TRIG_W = TRIG_FRAC_BITS + 2;
  localparam int CW     = vat_pkg::COORD_W;

  // Configuration registers
  logic [1:0]           mode;
  logic [1:0]           axis;
  logic signed [CW-1:0] amount_x;
  logic signed [CW-1:0] amount_y;
  logic signed [CW-1:0] amount_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= vat_pkg::MODE_TRANSLATE;
      axis     <= vat_pkg::AXIS_X;
      amount_x <= '0;
      amount_y <= '0;
      amount_z <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vat_pkg::REG_MODE:     mode     <= cfg_data[1:0];
        vat_pkg::REG_AXIS:     axis     <= cfg_data[1:0];
        vat_pkg::REG_AMOUNT_X: amount_x <= cfg_data;
        vat_pkg::REG_AMOUNT_Y: amount_y <= cfg_data;
        vat_pkg::REG_AMOUNT_Z: amount_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sine / cosine latch
  logic signed [TRIG_W-1:0] sine;
  logic signed [TRIG_W-1:0] cosine;

  vat_trig #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_trig (
    .clk         (clk),
    .rst         (rst),
    .angle_write (cfg_write && (cfg_index == vat_pkg::REG_ANGLE)),
    .angle       (cfg_data[vat_pkg::ANGLE_W-1:0]),
    .sine        (sine),
    .cosine      (cosine)
  );

  // Pipeline control: a stage advances when empty or when the next advances
  logic v0, v1, v2, v3;
  logic adv0, adv1, adv2, adv3;

  assign adv3      = !v3 || !res_stall;
  assign adv2      = !v2 || adv3;
  assign adv1      = !v1 || adv2;
  assign adv0      = !v0 || adv1;
  assign vtx_stall = !adv0;
  assign res_valid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv0) v0 <= vtx_valid;
      if (adv1) v1 <= v0;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  // Stage 0: operand select
  vat_pkg::lane_op_t op_x_next, op_y_next, op_z_next;
  vat_pkg::lane_op_t op_x, op_y, op_z;

  vat_opsel u_opsel (
    .vertex   (vtx),
    .mode     (mode),
    .axis     (axis),
    .amount_x (amount_x),
    .amount_y (amount_y),
    .amount_z (amount_z),
    .sine     (CW'(sine)),
    .cosine   (CW'(cosine)),
    .op_x     (op_x_next),
    .op_y     (op_y_next),
    .op_z     (op_z_next)
  );

  // Tag and last travel beside the lanes
  logic [vat_pkg::TAG_W-1:0] tag0, tag1, tag2, tag3;
  logic                      last0, last1, last2, last3;

  always_ff @(posedge clk) begin
    if (adv0) begin
      op_x  <= op_x_next;
      op_y  <= op_y_next;
      op_z  <= op_z_next;
      tag0  <= vtx.vertex_tag;
      last0 <= vtx.last_in;
    end
    if (adv1) begin
      tag1  <= tag0;
      last1 <= last0;
    end
    if (adv2) begin
      tag2  <= tag1;
      last2 <= last1;
    end
    if (adv3) begin
      tag3  <= tag2;
      last3 <= last2;
    end
  end

  // Coordinate lanes
  vat_pkg::stage_en_t   lane_en;
  logic signed [CW-1:0] val_x, val_y, val_z;
  logic                 ov_x, ov_y, ov_z;

  assign lane_en = '{s1: adv1, s2: adv2, s3: adv3};

  vat_lane #(
    .FRAC_BITS      (FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_x (
    .clk   (clk),
    .en    (lane_en),
    .op    (op_x),
    .value (val_x),
    .ov    (ov_x)
  );

  vat_lane #(
    .FRAC_BITS      (FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_y (
    .clk   (clk),
    .en    (lane_en),
    .op    (op_y),
    .value (val_y),
    .ov    (ov_y)
  );

  vat_lane #(
    .FRAC_BITS      (FRAC_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_lane_z (
    .clk   (clk),
    .en    (lane_en),
    .op    (op_z),
    .value (val_z),
    .ov    (ov_z)
  );

  // Result assembly
  always_comb begin
    res.out_x    = val_x;
    res.out_y    = val_y;
    res.out_z    = val_z;
    res.out_tag  = tag3;
    res.last_out = last3;
    res.overflow = ov_x || ov_y || ov_z;
  end

  // Input stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    vtx_stall |-> (v0 && v1 && v2 && v3 && res_stall))
    else $error("input stalled with a free pipeline stage");

  // An input transfer always lands in stage 0
  a_accept_load: assert property (@(posedge clk) disable iff (rst)
    (vtx_valid && !vtx_stall) |=> v0)
    else $error("accepted vertex not captured");

  // A vertex in stage 2 moves to the output when the output is not stalled
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (v2 && !res_stall) |=> res_valid)
    else $error("pipeline failed to drain toward the output");

endmodule
